>>> rtl/wfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wfc_pkg: shared types and constants for the word frequency counter
// Widths, codes, state encoding and character class helpers.
// ----------------------------------------------------------------------------
package wfc_pkg;

    localparam int TableEntries  = 1024;
    localparam int MaxWordChars  = 25;
    localparam int MaxTokenChars = 1023;
    localparam int KeepChars     = MaxWordChars + 1;
    localparam int SlotW         = $clog2(TableEntries);
    localparam int FillW         = SlotW + 1;
    localparam int TokLenW       = 10;
    localparam int CountW        = 24;
    localparam int LenW          = 5;
    localparam int CharW         = 8;
    localparam int PosW          = 5;
    localparam int KeepW         = $clog2(KeepChars);
    localparam int WordW         = MaxWordChars * CharW;
    localparam int EntryW        = WordW + LenW + CountW;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_BYTE  = 2'd0;
    localparam t_kind KIND_EOT   = 2'd1;
    localparam t_kind KIND_READ  = 2'd2;
    localparam t_kind KIND_CLEAR = 2'd3;

    typedef logic [2:0] t_status;
    localparam t_status ST_COUNTED  = 3'd0;
    localparam t_status ST_NEW      = 3'd1;
    localparam t_status ST_REJECTED = 3'd2;
    localparam t_status ST_FULL     = 3'd3;
    localparam t_status ST_READ     = 3'd4;

    localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_BUMP,
        S_INS,
        S_OUT
    } t_state;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_letter(c) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_strip(input logic [7:0] c);
        return c == 8'h3A || c == 8'h21 || c == 8'h2C || c == 8'h3F ||
               c == 8'h29 || c == 8'h22;
    endfunction

endpackage
`default_nettype wire

>>> rtl/wfc_token.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wfc_token: token capture and classification
// Stores the first characters of the open token and flags; gives the
// verdict and the stripped word when the token ends.
// ----------------------------------------------------------------------------
module wfc_token (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire logic [7:0]                    i_char,
    input  wire logic                          i_clear,
    output logic                               o_open,
    output logic                               o_last,
    output logic                               o_ok,
    output logic [wfc_pkg::LenW-1:0]           o_len,
    output logic [wfc_pkg::WordW-1:0]          o_word
);
    import wfc_pkg::*;

    logic [7:0]         r_chars [KeepChars];
    logic [TokLenW-1:0] r_len;
    logic               r_dot;
    logic               r_bad;
    logic [7:0]         last_c;
    logic [TokLenW-1:0] n_len;
    logic [TokLenW-1:0] strip_n;

    assign n_len  = r_len + 1'b1;
    assign o_open = r_len != '0;
    assign o_last = n_len >= TokLenW'(MaxTokenChars);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_dot <= 1'b0;
            r_bad <= 1'b0;
        end else if (i_clear) begin
            r_len <= '0;
            r_dot <= 1'b0;
            r_bad <= 1'b0;
        end else if (i_push) begin
            r_len <= n_len;
            if (i_char == 8'h2E) begin
                r_dot <= 1'b1;
            end
            if (r_len != '0 && r_len <= TokLenW'(KeepChars) &&
                !is_alnum(r_chars[KeepW'(r_len - 1'b1)])) begin
                r_bad <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && r_len < TokLenW'(KeepChars)) begin
            r_chars[KeepW'(r_len)] <= i_char;
        end
    end

    always_comb begin
        last_c  = r_chars[KeepW'(r_len - 1'b1)];
        strip_n = is_strip(last_c) ? r_len - 1'b1 : r_len;
        o_ok    = !r_dot && !r_bad && r_len != '0 && r_len <= TokLenW'(KeepChars) &&
                  (is_strip(last_c) || is_alnum(last_c)) && strip_n != '0 &&
                  strip_n <= TokLenW'(MaxWordChars) && is_letter(r_chars[0]);
        o_len   = LenW'(strip_n);
        for (int k = 0; k < MaxWordChars; k++) begin
            o_word[k*CharW +: CharW] = (TokLenW'(k) < strip_n) ? r_chars[k] : 8'h00;
        end
    end

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= TokLenW'(MaxTokenChars)) else $error("token not cut");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clear |=> r_len == '0) else $error("token not cleared");
    a_dot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dot && !i_clear |=> r_dot) else $error("dot flag lost");

endmodule
`default_nettype wire

>>> rtl/wfc_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wfc_table: word table memory
// One entry per slot holding word, length and count; one read and one
// write port, read data registered.
// ----------------------------------------------------------------------------
module wfc_table (
    input  wire logic                          i_clk,
    input  wire logic [wfc_pkg::SlotW-1:0]     i_raddr,
    output logic [wfc_pkg::WordW-1:0]          o_rword,
    output logic [wfc_pkg::LenW-1:0]           o_rlen,
    output logic [wfc_pkg::CountW-1:0]         o_rcount,
    input  wire logic                          i_we,
    input  wire logic [wfc_pkg::SlotW-1:0]     i_waddr,
    input  wire logic [wfc_pkg::WordW-1:0]     i_wword,
    input  wire logic [wfc_pkg::LenW-1:0]      i_wlen,
    input  wire logic [wfc_pkg::CountW-1:0]    i_wcount
);
    import wfc_pkg::*;

    logic [EntryW-1:0] r_mem [TableEntries];
    logic [EntryW-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wword, i_wlen, i_wcount};
        end
        r_q <= r_mem[i_raddr];
    end

    assign {o_rword, o_rlen, o_rcount} = r_q;

endmodule
`default_nettype wire

>>> rtl/word_frequency_counter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// word_frequency_counter: token word counter with readback
// Counts whitespace-delimited words of a byte stream in an in-order table.
// ----------------------------------------------------------------------------
// Usage: one request channel (kind, text_byte, entry_index, char_position)
// and one result channel (status, slot, count, word_length, char_value),
// both valid/ready. A byte that does not end a token gives no result; the
// byte that reaches the token length limit ends the token like a space. A
// token end is registered and judged in idle; an accepted token walks the
// filled slots through the read port, each through the read and compare
// states, and ends in the bump or insert state. An entry read passes the
// read, compare and output states; a rejected token and a read at or beyond
// the fill count are answered from idle. A table clear gives no result. The
// block holds one request at a time; o_ready is low while it works and
// while a result waits, and rises the cycle after the result is taken. When
// the receiver stalls, the result is held in the output register and no new
// request is taken. Reset empties the table (fill count zero) and drops any
// open token; table contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module word_frequency_counter (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [1:0]                  i_kind,
    input  wire logic [7:0]                  i_text_byte,
    input  wire logic [9:0]                  i_entry_index,
    input  wire logic [4:0]                  i_char_position,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [2:0]                       o_status,
    output logic [9:0]                       o_slot,
    output logic [23:0]                      o_count,
    output logic [4:0]                       o_word_length,
    output logic [7:0]                       o_char_value
);
    import wfc_pkg::*;

    t_state             r_state, n_state;
    logic [FillW-1:0]   r_fill;
    logic [FillW-1:0]   r_idx;
    logic               r_isread;
    logic [PosW-1:0]    r_pos;
    logic [SlotW-1:0]   r_rslot;
    logic [WordW-1:0]   r_word;
    logic [LenW-1:0]    r_wlen;
    logic               r_ovalid;
    logic [2:0]         r_status;
    logic [9:0]         r_slot;
    logic [23:0]        r_count;
    logic [4:0]         r_olen;
    logic [7:0]         r_char;
    logic               r_cut;

    logic               acc, fin, tok_push, tok_clear, start_tok;
    logic               tok_open, tok_last, tok_ok;
    logic [LenW-1:0]    tok_len;
    logic [WordW-1:0]   tok_word;
    logic [SlotW-1:0]   raddr;
    logic [WordW-1:0]   m_word;
    logic [LenW-1:0]    m_len;
    logic [CountW-1:0]  m_count;
    logic               we;
    logic [SlotW-1:0]   waddr;
    logic [WordW-1:0]   wword;
    logic [LenW-1:0]    wlen;
    logic [CountW-1:0]  wcount;
    logic               hit;
    logic [CountW-1:0]  bumped;

    assign o_ready = r_state == S_IDLE && !r_ovalid && !r_cut;
    assign acc     = i_valid && o_ready;
    assign fin     = acc && tok_open &&
                     ((i_kind == KIND_BYTE && is_space(i_text_byte)) || i_kind == KIND_EOT);
    assign tok_push  = acc && i_kind == KIND_BYTE && !is_space(i_text_byte);
    assign tok_clear = r_cut;
    assign start_tok = fin || (tok_push && tok_last);

    wfc_token u_token (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (tok_push),
        .i_char  (i_text_byte),
        .i_clear (tok_clear),
        .o_open  (tok_open),
        .o_last  (tok_last),
        .o_ok    (tok_ok),
        .o_len   (tok_len),
        .o_word  (tok_word)
    );

    assign raddr = r_isread ? r_rslot : SlotW'(r_idx);

    wfc_table u_table (
        .i_clk    (i_clk),
        .i_raddr  (raddr),
        .o_rword  (m_word),
        .o_rlen   (m_len),
        .o_rcount (m_count),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wword  (wword),
        .i_wlen   (wlen),
        .i_wcount (wcount)
    );

    assign hit    = m_len == r_wlen && m_word == r_word;
    assign bumped = (m_count == CountMax) ? m_count : m_count + 1'b1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (r_cut) begin
                    if (!tok_ok) begin
                        n_state = S_IDLE;
                    end else if (r_fill == '0) begin
                        n_state = S_INS;
                    end else begin
                        n_state = S_RD;
                    end
                end else if (acc && i_kind == KIND_READ &&
                             {1'b0, i_entry_index} < FillW'(r_fill)) begin
                    n_state = S_RD;
                end
            end
            S_RD: n_state = S_CMP;
            S_CMP: begin
                if (r_isread) begin
                    n_state = S_OUT;
                end else if (hit) begin
                    n_state = S_BUMP;
                end else if (r_idx + 1'b1 >= r_fill) begin
                    n_state = S_INS;
                end else begin
                    n_state = S_RD;
                end
            end
            S_BUMP:  n_state = S_IDLE;
            S_INS:   n_state = S_IDLE;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        we     = 1'b0;
        waddr  = SlotW'(r_idx);
        wword  = r_word;
        wlen   = r_wlen;
        wcount = 24'd1;
        unique case (r_state)
            S_BUMP: begin
                we     = 1'b1;
                wword  = m_word;
                wlen   = m_len;
                wcount = bumped;
            end
            S_INS: begin
                we = r_fill < FillW'(TableEntries);
                waddr = SlotW'(r_fill);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_ovalid <= 1'b0;
            r_cut    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cut   <= start_tok;
            if (o_valid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (acc && i_kind == KIND_CLEAR) begin
                r_fill <= '0;
            end
            if (r_state == S_IDLE && r_cut && !tok_ok) begin
                r_ovalid <= 1'b1;
            end
            if (acc && i_kind == KIND_READ && {1'b0, i_entry_index} >= FillW'(r_fill)) begin
                r_ovalid <= 1'b1;
            end
            if (r_state == S_BUMP || r_state == S_OUT) begin
                r_ovalid <= 1'b1;
            end
            if (r_state == S_INS) begin
                r_ovalid <= 1'b1;
                if (r_fill < FillW'(TableEntries)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_isread <= i_kind == KIND_READ;
            r_rslot  <= SlotW'(i_entry_index);
            r_pos    <= i_char_position;
            r_idx    <= '0;
        end
        if (r_state == S_IDLE && r_cut) begin
            r_isread <= 1'b0;
            r_word   <= tok_word;
            r_wlen   <= tok_len;
            r_idx    <= '0;
            if (!tok_ok) begin
                r_status <= ST_REJECTED;
                r_slot   <= '0;
                r_count  <= '0;
                r_olen   <= '0;
                r_char   <= '0;
            end
        end
        if (acc && i_kind == KIND_READ && {1'b0, i_entry_index} >= FillW'(r_fill)) begin
            r_status <= ST_READ;
            r_slot   <= i_entry_index;
            r_count  <= '0;
            r_olen   <= '0;
            r_char   <= '0;
        end
        if (r_state == S_CMP && !r_isread && !hit) begin
            r_idx <= r_idx + 1'b1;
        end
        if (r_state == S_OUT) begin
            r_status <= ST_READ;
            r_slot   <= 10'(r_rslot);
            r_count  <= r_word[CountW-1:0];
            r_olen   <= r_wlen;
            r_char   <= r_word[WordW-1 -: CharW];
        end
        if (r_state == S_CMP && r_isread) begin
            r_wlen                 <= m_len;
            r_word[CountW-1:0]     <= m_count;
            r_word[WordW-1 -: CharW] <= (r_pos < PosW'(m_len) && r_pos < PosW'(MaxWordChars))
                                        ? m_word[r_pos*CharW +: CharW] : 8'h00;
        end
        if (r_state == S_BUMP) begin
            r_status <= ST_COUNTED;
            r_slot   <= 10'(r_idx);
            r_count  <= bumped;
            r_olen   <= r_wlen;
            r_char   <= '0;
        end
        if (r_state == S_INS) begin
            if (r_fill < FillW'(TableEntries)) begin
                r_status <= ST_NEW;
                r_slot   <= 10'(r_fill);
                r_count  <= 24'd1;
                r_olen   <= r_wlen;
            end else begin
                r_status <= ST_FULL;
                r_slot   <= '0;
                r_count  <= '0;
                r_olen   <= '0;
            end
            r_char <= '0;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_status      = r_status;
    assign o_slot        = r_slot;
    assign o_count       = r_count;
    assign o_word_length = r_olen;
    assign o_char_value  = r_char;

    a_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !o_ready) else $error("ready while busy");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FillW'(TableEntries)) else $error("fill count overflow");
    a_cut_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cut |-> r_state == S_IDLE) else $error("token end while busy");
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |=> r_state == S_IDLE) else $error("write not final");

endmodule
`default_nettype wire
